[hdl/hri_pkg.sv]
`timescale 1ns / 1ps

package hri_pkg;

    localparam int TREE_WORDS = 1024;
    localparam int TREE_AW    = $clog2(TREE_WORDS);

    typedef logic [TREE_AW-1:0] t_tree_addr;
    typedef logic [15:0]        t_tree_word;

    localparam logic [1:0] REQ_TREE_WRITE = 2'd0;
    localparam logic [1:0] REQ_START      = 2'd1;
    localparam logic [1:0] REQ_BYTE       = 2'd2;

    localparam logic CFG_SYMBOLS_PER_ROW = 1'b0;
    localparam logic CFG_ROW_COUNT       = 1'b1;

endpackage

[hdl/huffman_row_start_indexer.sv]
`timescale 1ns / 1ps
// A start request queues its row record and passes it through the flush state to the
// output register, where it waits while the output stalls. A stream byte is walked
// bit by bit: a node read, then per bit a child offset read and a child read through an
// inner node, then the hand-over of a pending record; a new request is taken only when
// the walk is back in idle. Config writes are always accepted.
// Reset (synchronous, active low) idles the walk; the tree memory is not cleared.
module huffman_row_start_indexer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [9:0]           i_tree_word_addr,
    input  logic signed [15:0]   i_tree_word_value,
    input  logic [7:0]           i_stream_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_row_byte_pos,
    output logic [2:0]           o_row_bits_left,
    output logic                 o_decode_done,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import hri_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NODE  = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_OFF   = 3'd3;
    localparam logic [2:0] S_CHILD = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    t_tree_word mem [TREE_WORDS];
    t_tree_word r_rdata;

    logic [2:0]  r_state, n_state;
    logic        r_running, n_running;
    t_tree_addr  r_node, n_node;
    t_tree_word  r_cur, n_cur;
    t_tree_word  r_root, n_root;
    logic [7:0]  r_buf, n_buf;
    logic [2:0]  r_k, n_k;
    logic [15:0] r_byte_pos, n_byte_pos;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [15:0] r_spr, n_spr;
    logic [15:0] r_rows, n_rows;

    logic        r_pend_valid, n_pend_valid;
    logic [15:0] r_pend_pos, n_pend_pos;
    logic [2:0]  r_pend_bl, n_pend_bl;
    logic        r_pend_done, n_pend_done;

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_pos, n_out_pos;
    logic [2:0]  r_out_bl, n_out_bl;
    logic        r_out_done, n_out_done;
    logic        r_out_last, n_out_last;

    logic        w_in_acc;
    logic        w_mem_we;
    t_tree_addr  w_wr_addr;
    logic        w_mem_re;
    t_tree_addr  w_rd_addr;
    logic        w_bit;
    logic        w_bit_next;
    logic [15:0] w_off_half;
    logic [15:0] w_col_inc;
    logic [15:0] w_row_inc;
    logic        w_is_row;
    logic        w_is_done;
    logic        w_can_push;
    logic        w_sym_end;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign o_out_valid     = r_out_valid;
    assign o_row_byte_pos  = $signed(r_out_pos);
    assign o_row_bits_left = r_out_bl;
    assign o_decode_done   = r_out_done;
    assign o_last          = r_out_last;

    assign w_mem_we   = w_in_acc && (i_req_type == REQ_TREE_WRITE);
    assign w_wr_addr  = TREE_AW'(i_tree_word_addr);
    assign w_bit      = r_buf[r_k];
    assign w_bit_next = r_buf[r_k - 3'd1];
    // floor(offset / 2), sign kept, then wrapped to the table
    assign w_off_half = {r_rdata[15], r_rdata[15:1]};
    assign w_col_inc  = r_col + 16'd1;
    assign w_row_inc  = r_row + 16'd1;
    // a zero register wraps to 65536 naturally through the 16-bit compare
    assign w_is_row   = (w_col_inc == r_spr);
    assign w_is_done  = (w_row_inc == r_rows);
    assign w_can_push = !r_out_valid || i_out_ready;
    assign w_sym_end  = ((r_state == S_BIT) && !r_cur[15]) ||
                        ((r_state == S_CHILD) && !r_rdata[15]);

    always_comb begin
        n_state      = r_state;
        n_running    = r_running;
        n_node       = r_node;
        n_cur        = r_cur;
        n_root       = r_root;
        n_buf        = r_buf;
        n_k          = r_k;
        n_byte_pos   = r_byte_pos;
        n_col        = r_col;
        n_row        = r_row;
        n_spr        = r_spr;
        n_rows       = r_rows;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_pend_bl    = r_pend_bl;
        n_pend_done  = r_pend_done;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_pos    = r_out_pos;
        n_out_bl     = r_out_bl;
        n_out_done   = r_out_done;
        n_out_last   = r_out_last;
        w_mem_re     = 1'b0;
        w_rd_addr    = r_node;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYMBOLS_PER_ROW: n_spr  = i_cfg_data;
                CFG_ROW_COUNT:       n_rows = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_req_type)
                        REQ_TREE_WRITE: begin
                            if (w_wr_addr == '0) begin
                                n_root = i_tree_word_value;
                            end
                        end
                        REQ_START: begin
                            n_node       = '0;
                            n_k          = 3'd0;
                            n_byte_pos   = 16'hFFFF;
                            n_col        = 16'd0;
                            n_row        = 16'd0;
                            n_running    = 1'b1;
                            n_pend_valid = 1'b1;
                            n_pend_pos   = 16'hFFFF;
                            n_pend_bl    = 3'd0;
                            n_pend_done  = 1'b0;
                            n_state      = S_FLUSH;
                        end
                        REQ_BYTE: begin
                            if (r_running) begin
                                n_buf      = i_stream_byte;
                                n_byte_pos = r_byte_pos + 16'd1;
                                n_k        = 3'd7;
                                w_mem_re   = 1'b1;
                                w_rd_addr  = r_node;
                                n_state    = S_NODE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_NODE: begin
                n_cur   = r_rdata;
                n_state = S_BIT;
            end
            S_BIT: begin
                if (r_cur[15]) begin
                    w_mem_re  = 1'b1;
                    w_rd_addr = TREE_AW'(r_node + t_tree_addr'(1) + t_tree_addr'(w_bit));
                    n_state   = S_OFF;
                end
            end
            S_OFF: begin
                w_mem_re  = 1'b1;
                w_rd_addr = w_off_half[TREE_AW-1:0];
                n_node    = w_off_half[TREE_AW-1:0];
                n_state   = S_CHILD;
            end
            S_CHILD: begin
                if (r_rdata[15]) begin
                    // still inside the tree: bit consumed, walk on with the next one
                    n_cur = r_rdata;
                    if (r_k == 3'd0) begin
                        n_state = r_pend_valid ? S_FLUSH : S_IDLE;
                    end else begin
                        n_k       = r_k - 3'd1;
                        w_mem_re  = 1'b1;
                        w_rd_addr = TREE_AW'(r_node + t_tree_addr'(1) +
                                             t_tree_addr'(w_bit_next));
                        n_state   = S_OFF;
                    end
                end
            end
            S_FLUSH: begin
                if (w_can_push) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = r_pend_pos;
                    n_out_bl     = r_pend_bl;
                    n_out_done   = r_pend_done;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // symbol ends on the current bit
        if (w_sym_end && !(w_is_row && r_pend_valid && !w_can_push)) begin
            n_node = '0;
            n_cur  = r_root;
            if (w_is_row) begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_pend_pos;
                    n_out_bl    = r_pend_bl;
                    n_out_done  = r_pend_done;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_pos   = w_is_done ? 16'd0 : r_byte_pos;
                n_pend_bl    = w_is_done ? 3'd0 : r_k;
                n_pend_done  = w_is_done;
                n_col        = 16'd0;
                n_row        = w_row_inc;
                if (w_is_done) begin
                    n_running = 1'b0;
                    n_state   = S_FLUSH;
                end else if (r_k == 3'd0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_k     = r_k - 3'd1;
                    n_state = S_BIT;
                end
            end else begin
                n_col = w_col_inc;
                if (r_k == 3'd0) begin
                    n_state = r_pend_valid ? S_FLUSH : S_IDLE;
                end else begin
                    n_k     = r_k - 3'd1;
                    n_state = S_BIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_wr_addr] <= i_tree_word_value;
        end
        if (w_mem_re) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_running    <= 1'b0;
            r_node       <= '0;
            r_k          <= 3'd0;
            r_byte_pos   <= 16'hFFFF;
            r_col        <= 16'd0;
            r_row        <= 16'd0;
            r_spr        <= 16'd1;
            r_rows       <= 16'd1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_running    <= n_running;
            r_node       <= n_node;
            r_k          <= n_k;
            r_byte_pos   <= n_byte_pos;
            r_col        <= n_col;
            r_row        <= n_row;
            r_spr        <= n_spr;
            r_rows       <= n_rows;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_root      <= n_root;
        r_buf       <= n_buf;
        r_pend_pos  <= n_pend_pos;
        r_pend_bl   <= n_pend_bl;
        r_pend_done <= n_pend_done;
        r_out_pos   <= n_out_pos;
        r_out_bl    <= n_out_bl;
        r_out_done  <= n_out_done;
        r_out_last  <= n_out_last;
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending result left behind in idle");

    a_walk_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_FLUSH) |-> r_running)
        else $error("tree walk active while not running");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("done result not marked last");

    a_start_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req_type == REQ_START) |=>
        (r_state == S_FLUSH && r_pend_valid && !r_pend_done &&
         r_pend_pos == 16'hFFFF && r_pend_bl == 3'd0))
        else $error("start request did not queue the first row record");

endmodule

[tb/sv/tb_huffman_row_start_indexer.sv]
`timescale 1ns / 1ps

module tb_huffman_row_start_indexer;
    import hri_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] pos;
        logic [2:0]  bits;
        logic        done;
        logic        last;
    } t_row_rec;

    // Tree walker shadow: holds its own table, walk state and registers,
    // and queues the row records each request should produce.
    class row_start_scoreboard;
        logic [15:0] tree_mem [TREE_WORDS];
        t_tree_addr  node_ptr;
        logic [7:0]  cur_byte;
        logic [2:0]  bits_left;
        logic [15:0] byte_pos;
        logic [15:0] col_cnt;
        logic [15:0] row_idx;
        logic [15:0] sym_per_row;
        logic [15:0] row_limit;
        bit          running;
        t_row_rec    expected_q[$];
        int          fails;

        function new();
            node_ptr    = '0;
            cur_byte    = '0;
            bits_left   = '0;
            byte_pos    = 16'hFFFF;
            col_cnt     = '0;
            row_idx     = '0;
            sym_per_row = 16'd1;
            row_limit   = 16'd1;
            running     = 1'b0;
            fails       = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] data);
            if (idx == CFG_SYMBOLS_PER_ROW)
                sym_per_row = data;
            else
                row_limit = data;
        endfunction

        function void push_rec(logic [15:0] pos, logic [2:0] bits, logic done);
            t_row_rec rec;
            rec.pos  = pos;
            rec.bits = bits;
            rec.done = done;
            rec.last = 1'b0;
            expected_q.push_back(rec);
        endfunction

        function void note_request(logic [1:0] req, t_tree_addr addr, logic [15:0] value,
                                   logic [7:0] sbyte);
            int          k;
            int          n0;
            logic        b;
            logic [15:0] off;
            bit          sym_end;
            case (req)
                REQ_TREE_WRITE: tree_mem[addr] = value;
                REQ_START: begin
                    node_ptr  = '0;
                    cur_byte  = '0;
                    bits_left = '0;
                    byte_pos  = 16'hFFFF;
                    col_cnt   = '0;
                    row_idx   = '0;
                    running   = 1'b1;
                    push_rec(byte_pos, bits_left, 1'b0);
                    expected_q[expected_q.size() - 1].last = 1'b1;
                end
                REQ_BYTE: begin
                    if (running) begin
                        cur_byte = sbyte;
                        byte_pos = byte_pos + 16'd1;
                        n0 = expected_q.size();
                        for (k = 7; k >= 0; k--) begin
                            b = cur_byte[k];
                            bits_left = 3'(k);
                            sym_end = 1'b1;
                            // a leaf reached with no bit still eats this one
                            if (tree_mem[node_ptr][15]) begin
                                off = tree_mem[t_tree_addr'(node_ptr + 1 + b)];
                                node_ptr = off[TREE_AW:1];
                                sym_end = !tree_mem[node_ptr][15];
                            end
                            if (sym_end) begin
                                node_ptr = '0;
                                col_cnt = col_cnt + 16'd1;
                                if (col_cnt == sym_per_row) begin
                                    col_cnt = '0;
                                    row_idx = row_idx + 16'd1;
                                    if (row_idx == row_limit) begin
                                        push_rec(16'd0, 3'd0, 1'b1);
                                        running = 1'b0;
                                        break;
                                    end
                                    push_rec(byte_pos, bits_left, 1'b0);
                                end
                            end
                        end
                        if (expected_q.size() > n0)
                            expected_q[expected_q.size() - 1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            fails++;
        endfunction

        function void check_row_record(logic [15:0] pos, logic [2:0] bits, logic done,
                                       logic last);
            t_row_rec exp_rec;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected record pos=%0d bits=%0d done=%0b",
                                 $signed(pos), bits, done));
                return;
            end
            exp_rec = expected_q.pop_front();
            if (pos !== exp_rec.pos)
                report($sformatf("row_byte_pos %0d, want %0d", $signed(pos),
                                 $signed(exp_rec.pos)));
            if (bits !== exp_rec.bits)
                report($sformatf("row_bits_left %0d, want %0d", bits, exp_rec.bits));
            if (done !== exp_rec.done)
                report($sformatf("decode_done %0b, want %0b", done, exp_rec.done));
            if (last !== exp_rec.last)
                report($sformatf("last %0b, want %0b", last, exp_rec.last));
        endfunction
    endclass

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic [1:0]         i_req_type        = '0;
    logic [9:0]         i_tree_word_addr  = '0;
    logic signed [15:0] i_tree_word_value = '0;
    logic [7:0]         i_stream_byte     = '0;
    logic               i_out_ready       = 1'b0;
    logic               i_cfg_valid       = 1'b0;
    logic               i_cfg_index       = 1'b0;
    logic [15:0]        i_cfg_data        = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [15:0] o_row_byte_pos;
    logic [2:0]         o_row_bits_left;
    logic               o_decode_done;
    logic               o_last;
    logic               o_cfg_ready;

    huffman_row_start_indexer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_tree_word_addr  (i_tree_word_addr),
        .i_tree_word_value (i_tree_word_value),
        .i_stream_byte     (i_stream_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_row_byte_pos    (o_row_byte_pos),
        .o_row_bits_left   (o_row_bits_left),
        .o_decode_done     (o_decode_done),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    row_start_scoreboard sb;

    int  item_cnt   = 0;
    int  stall_left = 0;
    bit  idle_en    = 1'b1;
    bit  quiet      = 1'b0;

    // current random tree: node 0 is the root at word 0
    t_tree_addr node_addr [32];
    bit         node_inner [32];
    int         kid_l [32];
    int         kid_r [32];
    int         n_nodes = 0;
    bit         in_tree [TREE_WORDS];
    bit         have_tree = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_en && !quiet && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(1, 14) - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_row_record(o_row_byte_pos, o_row_bits_left, o_decode_done, o_last);
    end

    // valid is left high after acceptance; a gap before the next request or a wait lowers it
    task automatic send_req(logic [1:0] req, t_tree_addr addr, logic [15:0] value,
                            logic [7:0] sbyte);
        int gap;
        gap = 0;
        if (idle_en && !quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= req;
        i_tree_word_addr  <= addr;
        i_tree_word_value <= value;
        i_stream_byte     <= sbyte;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (req == REQ_TREE_WRITE || req == REQ_START || (req == REQ_BYTE && sb.running))
            item_cnt++;
        sb.note_request(req, addr, value, sbyte);
    endtask

    task automatic send_write(t_tree_addr addr, logic [15:0] value);
        send_req(REQ_TREE_WRITE, addr, value, 8'($urandom));
    endtask

    task automatic send_start();
        send_req(REQ_START, t_tree_addr'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_byte(logic [7:0] sbyte);
        send_req(REQ_BYTE, t_tree_addr'($urandom), 16'($urandom), sbyte);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        // a byte that ends no row may still be walking
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] spr, logic [15:0] rows);
        wait_idle();
        for (int r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (r == 0) ? CFG_SYMBOLS_PER_ROW : CFG_ROW_COUNT;
            i_cfg_data  <= (r == 0) ? spr : rows;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg((r == 0) ? CFG_SYMBOLS_PER_ROW : CFG_ROW_COUNT, (r == 0) ? spr : rows);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // byte offset of a node: junk above bit 10 and in bit 0 must not matter
    function automatic logic [15:0] child_offset(int idx);
        return {5'($urandom), node_addr[idx], 1'($urandom)};
    endfunction

    task automatic build_tree();
        int         k;
        int         j;
        int         base;
        t_tree_addr a;
        k = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 6);
        base = $urandom_range(3, 980);
        n_nodes = 1;
        node_addr[0]  = '0;
        node_inner[0] = 1'b0;
        repeat (k) begin
            j = $urandom_range(0, n_nodes - 1);
            while (node_inner[j]) j = $urandom_range(0, n_nodes - 1);
            node_inner[j] = 1'b1;
            kid_l[j] = n_nodes;
            kid_r[j] = n_nodes + 1;
            node_addr[n_nodes]      = t_tree_addr'(base + 3 * (n_nodes - 1));
            node_addr[n_nodes + 1]  = t_tree_addr'(base + 3 * n_nodes);
            node_inner[n_nodes]     = 1'b0;
            node_inner[n_nodes + 1] = 1'b0;
            n_nodes += 2;
        end
        foreach (in_tree[i]) in_tree[i] = 1'b0;
        for (j = 0; j < n_nodes; j++) begin
            a = node_addr[j];
            in_tree[a] = 1'b1;
            send_write(a, {node_inner[j], 15'($urandom)});
            if (node_inner[j]) begin
                in_tree[t_tree_addr'(a + 1)] = 1'b1;
                in_tree[t_tree_addr'(a + 2)] = 1'b1;
                send_write(t_tree_addr'(a + 1), child_offset(kid_l[j]));
                send_write(t_tree_addr'(a + 2), child_offset(kid_r[j]));
            end
        end
    endtask

    // rewrite during a walk, keeping every reachable word written
    task automatic rewrite_node();
        int         j;
        t_tree_addr a;
        j = $urandom_range(0, n_nodes - 1);
        a = node_addr[j];
        if (!node_inner[j])
            send_write(a, {1'b0, 15'($urandom)});
        else if ($urandom_range(0, 1) == 1)
            send_write(a, 16'($urandom));
        else
            send_write(t_tree_addr'(a + 1 + $urandom_range(0, 1)),
                       child_offset($urandom_range(0, n_nodes - 1)));
    endtask

    task automatic send_noise();
        t_tree_addr a;
        if ($urandom_range(0, 1) == 1) begin
            send_req(REQ_UNUSED, t_tree_addr'($urandom), 16'($urandom), 8'($urandom));
        end else begin
            a = t_tree_addr'($urandom);
            while (in_tree[a]) a = t_tree_addr'($urandom);
            send_write(a, 16'($urandom));
        end
    endtask

    task automatic run_phase(logic [15:0] spr, logic [15:0] rows, int budget);
        int stop_at;
        int nbytes;
        int r;
        write_regs(spr, rows);
        idle_en = ($urandom_range(0, 3) != 0);
        stop_at = item_cnt + budget;
        while (item_cnt < stop_at) begin
            if (!have_tree || $urandom_range(0, 2) == 0) begin
                build_tree();
                have_tree = 1'b1;
            end
            send_start();
            nbytes = $urandom_range(1, 24);
            for (int n = 0; n < nbytes && item_cnt < stop_at; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    rewrite_node();
                else if (r < 10)
                    send_noise();
                else if (r < 12)
                    send_start();
                send_byte(8'($urandom));
                if (!sb.running)
                    break;
            end
            if ($urandom_range(0, 3) == 0)
                send_byte(8'($urandom));
        end
    endtask

    initial begin
        int waited;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing happens for a byte while idle or for the unused code
        send_byte(8'hFF);
        send_req(REQ_UNUSED, 10'h3FF, 16'hFFFF, 8'hFF);
        // leaf at the root: every bit is a whole symbol
        send_write(10'd0, 16'h7FFF);
        send_start();
        send_byte(8'h00);
        send_byte(8'h55);

        write_regs(16'd1, 16'd9);
        send_start();
        send_byte(8'hFF);
        send_byte(8'h80);
        send_start();
        send_start();

        // node at the top word takes its offsets from words 0 and 1
        write_regs(16'd2, 16'hFFFF);
        send_write(10'd5, 16'h0000);
        send_write(10'd6, 16'h7FFF);
        send_write(10'd1023, 16'h8000);
        send_write(10'd0, 16'h800B);
        send_write(10'd1, 16'h07FF);
        send_write(10'd2, 16'hF80C);
        send_start();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_write(10'd1023, 16'h0001);
        send_byte(8'h3C);
        send_byte(8'hC3);

        run_phase(16'd1, 16'd1, 60);
        run_phase(16'd3, 16'd4, 60);
        run_phase(16'd1, 16'hFFFF, 50);
        run_phase(16'hFFFF, 16'd2, 20);
        run_phase(16'd0, 16'd0, 20);
        run_phase(16'd2, 16'd1, 50);
        run_phase(16'($urandom), 16'($urandom), 15);
        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)), 60);
        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)), 60);
        quiet = 1'b1;
        run_phase(16'd5, 16'd3, 60);

        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.expected_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (64) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d records never arrived", sb.expected_q.size()));
        if (sb.fails == 0)
            $display("tb_huffman_row_start_indexer OK");
        else
            $display("tb_huffman_row_start_indexer NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_huffman_row_start_indexer NOT OK");
        $finish;
    end

endmodule

[sim.f]
hdl/hri_pkg.sv
hdl/huffman_row_start_indexer.sv
tb/sv/tb_huffman_row_start_indexer.sv
